// File: hdl/prs_pkg.sv
// Shared types and codes for the packet rate shaper.
package prs_pkg;

    localparam int RATE_W = 24;
    localparam int USED_W = 25;

    localparam logic [1:0] KIND_ARRIVE = 2'd0;
    localparam logic [1:0] KIND_TICK   = 2'd1;
    localparam logic [1:0] KIND_FLUSH  = 2'd2;

    localparam logic [1:0] VERDICT_PASS   = 2'd0;
    localparam logic [1:0] VERDICT_QUEUED = 2'd1;
    localparam logic [1:0] VERDICT_FULL   = 2'd2;
    localparam logic [1:0] VERDICT_RATE0  = 2'd3;

    localparam logic [1:0] CFG_SEND_RATE    = 2'd0;
    localparam logic [1:0] CFG_RECV_RATE    = 2'd1;
    localparam logic [1:0] CFG_BUFFER_LIMIT = 2'd2;

    localparam logic [RATE_W-1:0] CFG_RESET_VALUE = 24'h010000;

    typedef struct packed {
        logic [1:0]  kind;
        logic        direction;
        logic [15:0] pkt_length;
        logic [15:0] pkt_handle;
        logic        drop_queued;
    } prs_in_t;

    typedef struct packed {
        logic        is_release;
        logic        out_direction;
        logic [15:0] out_handle;
        logic [15:0] out_length;
        logic [1:0]  verdict;
        logic        discarded;
        logic        last;
    } prs_out_t;

    // controller -> datapath
    typedef struct packed {
        logic       do_arrive;
        logic       do_release;
        logic       rel_dir;
        logic       rel_all;
        logic       rel_disc;
        logic [1:0] clear_used;
    } prs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       out_free;
        logic [1:0] nonempty;
        logic [1:0] budget;
        logic       more_same;
    } prs_sts_t;

endpackage

// File: hdl/prs_datapath.sv
// Datapath: config registers, descriptor queues, byte counters, result register.
module prs_datapath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    input  logic [1:0]                cfg_index,
    input  logic [prs_pkg::RATE_W-1:0] cfg_wdata,
    input  prs_pkg::prs_in_t          s_data,
    input  prs_pkg::prs_cmd_t         cmd,
    output prs_pkg::prs_sts_t         sts,
    output logic                      m_valid,
    output prs_pkg::prs_out_t         m_data,
    input  logic                      m_ready
);
    import prs_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C   = CW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(QUEUE_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_W   = (AW+1)'(QUEUE_DEPTH);

    logic [RATE_W-1:0] send_rate_reg, recv_rate_reg, limit_reg;
    logic [CW-1:0]     count_reg [2];
    logic [CW-1:0]     count_next [2];
    logic [AW-1:0]     head_reg [2];
    logic [AW-1:0]     head_next [2];
    logic [USED_W-1:0] used_reg [2];
    logic [USED_W-1:0] used_next [2];
    logic [USED_W-1:0] buf_reg, buf_next;
    logic              m_valid_reg, m_valid_next;
    prs_out_t          m_data_reg, m_data_next;

    logic [31:0] send_mem [QUEUE_DEPTH];
    logic [31:0] recv_mem [QUEUE_DEPTH];
    logic [31:0] rd_send_reg, rd_recv_reg;

    // arrival path
    logic              ad;
    logic [RATE_W-1:0] a_rate;
    logic [CW-1:0]     a_cnt;
    logic [USED_W:0]   a_sum, a_buf_sum;
    logic              a_pass, a_full;
    logic [1:0]        a_verdict;
    logic [AW:0]       wsum;
    logic [AW-1:0]     waddr;
    logic              wr_en;

    // release path
    logic              rd;
    logic [31:0]       r_entry;
    logic [15:0]       r_len;
    logic [RATE_W-1:0] r_rate;
    logic [CW-1:0]     r_cnt;
    logic [USED_W:0]   r_sum;
    logic [USED_W-1:0] r_used_new;
    logic              av1, r_last;

    assign ad        = s_data.direction;
    assign a_rate    = ad ? recv_rate_reg : send_rate_reg;
    assign a_cnt     = count_reg[ad];
    assign a_sum     = {1'b0, used_reg[ad]} + (USED_W+1)'(s_data.pkt_length);
    assign a_buf_sum = {1'b0, buf_reg} + (USED_W+1)'(s_data.pkt_length);
    assign a_pass    = (a_cnt == '0) && (a_sum <= (USED_W+1)'(a_rate));
    assign a_full    = (a_buf_sum > (USED_W+1)'(limit_reg)) || (a_cnt >= DEPTH_C);
    assign wsum      = {1'b0, head_reg[ad]} + (AW+1)'(a_cnt);
    assign waddr     = (wsum >= DEPTH_W) ? AW'(wsum - DEPTH_W) : AW'(wsum);

    always_comb begin
        if (a_rate == '0) begin
            a_verdict = VERDICT_RATE0;
        end else if (a_pass) begin
            a_verdict = VERDICT_PASS;
        end else if (a_full) begin
            a_verdict = VERDICT_FULL;
        end else begin
            a_verdict = VERDICT_QUEUED;
        end
    end

    assign wr_en = cmd.do_arrive && (a_verdict == VERDICT_QUEUED);

    assign rd         = cmd.rel_dir;
    assign r_entry    = rd ? rd_recv_reg : rd_send_reg;
    assign r_len      = r_entry[15:0];
    assign r_rate     = rd ? recv_rate_reg : send_rate_reg;
    assign r_cnt      = count_reg[rd];
    assign r_sum      = {1'b0, used_reg[rd]} + (USED_W+1)'(r_len);
    assign r_used_new = r_sum[USED_W] ? {USED_W{1'b1}} : r_sum[USED_W-1:0];

    assign sts.out_free    = !m_valid_reg || m_ready;
    assign sts.nonempty[0] = (count_reg[0] != '0);
    assign sts.nonempty[1] = (count_reg[1] != '0);
    assign sts.budget[0]   = (send_rate_reg == '0) || (used_reg[0] < USED_W'(send_rate_reg));
    assign sts.budget[1]   = (recv_rate_reg == '0) || (used_reg[1] < USED_W'(recv_rate_reg));
    assign sts.more_same   = (r_cnt > CW'(1)) &&
                             (cmd.rel_all || (r_rate == '0) || (r_sum < (USED_W+1)'(r_rate)));

    // receive queue still pending after the send queue runs dry
    assign av1    = sts.nonempty[1] && (cmd.rel_all || sts.budget[1]);
    assign r_last = !(sts.more_same || (!rd && av1));

    always_comb begin
        count_next   = count_reg;
        head_next    = head_reg;
        used_next    = used_reg;
        buf_next     = buf_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (cmd.do_arrive) begin
            if (a_verdict == VERDICT_PASS) begin
                used_next[ad] = a_sum[USED_W-1:0];
            end
            if (a_verdict == VERDICT_QUEUED) begin
                count_next[ad] = a_cnt + CW'(1);
                buf_next       = a_buf_sum[USED_W-1:0];
            end
            m_valid_next              = 1'b1;
            m_data_next.is_release    = 1'b0;
            m_data_next.out_direction = ad;
            m_data_next.out_handle    = s_data.pkt_handle;
            m_data_next.out_length    = s_data.pkt_length;
            m_data_next.verdict       = a_verdict;
            m_data_next.discarded     = 1'b0;
            m_data_next.last          = 1'b1;
        end
        if (cmd.do_release) begin
            head_next[rd]  = (head_reg[rd] == LAST_ADDR) ? '0 : head_reg[rd] + AW'(1);
            count_next[rd] = r_cnt - CW'(1);
            used_next[rd]  = r_used_new;
            buf_next       = (buf_reg >= USED_W'(r_len)) ? buf_reg - USED_W'(r_len) : '0;
            m_valid_next              = 1'b1;
            m_data_next.is_release    = 1'b1;
            m_data_next.out_direction = rd;
            m_data_next.out_handle    = r_entry[31:16];
            m_data_next.out_length    = r_len;
            m_data_next.verdict       = VERDICT_PASS;
            m_data_next.discarded     = cmd.rel_disc;
            m_data_next.last          = r_last;
        end
        if (cmd.clear_used[0]) begin
            used_next[0] = '0;
        end
        if (cmd.clear_used[1]) begin
            used_next[1] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            send_rate_reg <= CFG_RESET_VALUE;
            recv_rate_reg <= CFG_RESET_VALUE;
            limit_reg     <= CFG_RESET_VALUE;
            count_reg[0]  <= '0;
            count_reg[1]  <= '0;
            head_reg[0]   <= '0;
            head_reg[1]   <= '0;
            used_reg[0]   <= '0;
            used_reg[1]   <= '0;
            buf_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_SEND_RATE:    send_rate_reg <= cfg_wdata;
                    CFG_RECV_RATE:    recv_rate_reg <= cfg_wdata;
                    CFG_BUFFER_LIMIT: limit_reg     <= cfg_wdata;
                    default: ;
                endcase
            end
            count_reg   <= count_next;
            head_reg    <= head_next;
            used_reg    <= used_next;
            buf_reg     <= buf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    // descriptor stores, registered read at the queue head
    always_ff @(posedge aclk) begin
        if (wr_en && !ad) begin
            send_mem[waddr] <= {s_data.pkt_handle, s_data.pkt_length};
        end
        rd_send_reg <= send_mem[head_reg[0]];
    end

    always_ff @(posedge aclk) begin
        if (wr_en && ad) begin
            recv_mem[waddr] <= {s_data.pkt_handle, s_data.pkt_length};
        end
        rd_recv_reg <= recv_mem[head_reg[1]];
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: hdl/prs_ctrl.sv
// Controller: accepts requests and sequences queue drains for tick and flush.
module prs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  prs_pkg::prs_in_t  s_data,
    input  prs_pkg::prs_sts_t sts,
    output prs_pkg::prs_cmd_t cmd
);
    import prs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   dir_reg, dir_next;
    logic   all_reg, all_next;
    logic   disc_reg, disc_next;

    logic   req_all;
    logic   av0_req, av1_req, av1_cur;

    assign s_ready = (state_reg == ST_IDLE) && sts.out_free;

    assign req_all = (s_data.kind == KIND_FLUSH);
    assign av0_req = sts.nonempty[0] && (req_all || sts.budget[0]);
    assign av1_req = sts.nonempty[1] && (req_all || sts.budget[1]);
    assign av1_cur = sts.nonempty[1] && (all_reg || sts.budget[1]);

    always_comb begin
        state_next     = state_reg;
        dir_next       = dir_reg;
        all_next       = all_reg;
        disc_next      = disc_reg;
        cmd            = '0;
        cmd.rel_dir    = dir_reg;
        cmd.rel_all    = all_reg;
        cmd.rel_disc   = disc_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    case (s_data.kind)
                        KIND_ARRIVE: cmd.do_arrive = 1'b1;
                        KIND_TICK, KIND_FLUSH: begin
                            all_next  = req_all;
                            disc_next = req_all && s_data.drop_queued;
                            if (av0_req) begin
                                dir_next   = 1'b0;
                                state_next = ST_FETCH;
                            end else begin
                                cmd.clear_used[0] = 1'b1;
                                if (av1_req) begin
                                    dir_next   = 1'b1;
                                    state_next = ST_FETCH;
                                end else begin
                                    cmd.clear_used[1] = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_FETCH: state_next = ST_EMIT;
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.do_release = 1'b1;
                    if (sts.more_same) begin
                        state_next = ST_FETCH;
                    end else begin
                        cmd.clear_used[dir_reg] = 1'b1;
                        if (!dir_reg && av1_cur) begin
                            dir_next   = 1'b1;
                            state_next = ST_FETCH;
                        end else begin
                            cmd.clear_used[1] = 1'b1;
                            state_next        = ST_IDLE;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            dir_reg   <= 1'b0;
            all_reg   <= 1'b0;
            disc_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            dir_reg   <= dir_next;
            all_reg   <= all_next;
            disc_reg  <= disc_next;
        end
    end

endmodule

// File: hdl/packet_rate_shaper_unit.sv
// Top level of the two-direction per-tick byte budget packet shaper.
// Arrival: verdict appears on m_ in the cycle after the request; one arrival per
//   cycle while m_ is free and no drain runs. Tick or flush: accepted in IDLE,
//   then FETCH and EMIT per packet, for the registered descriptor store read.
// A tick or flush with nothing to release is done in its accept cycle.
// Reset (aresetn low, synchronous): queues empty, byte counters zero, all three
//   config registers 65536; descriptor stores are not cleared.
module packet_rate_shaper_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // packet / tick / flush requests
    input  logic                       s_valid,
    output logic                       s_ready,
    input  prs_pkg::prs_in_t           s_data,
    // verdicts and releases
    output logic                       m_valid,
    input  logic                       m_ready,
    output prs_pkg::prs_out_t          m_data,
    // config writes
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [prs_pkg::RATE_W-1:0] cfg_wdata
);
    import prs_pkg::*;

    prs_cmd_t cmd;
    prs_sts_t sts;

    // config writes land at once; user keeps them issued only while idle, unguarded
    assign cfg_ready = 1'b1;

    // Controller: IDLE takes a request when the result register is free.
    // Arrivals are judged in that cycle; tick and flush walk send then receive,
    // alternating FETCH (head read) and EMIT (pop into the result register).
    prs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath: rates, limit, per-direction queues and used counts, and the
    // output register that decouples results from the next request.
    prs_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .m_ready   (m_ready)
    );

endmodule

// File: hdl/prs_checker.sv
// Port-level checks for the packet rate shaper, bound to the top level.
module prs_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input prs_pkg::prs_in_t           s_data,
    input logic                       m_valid,
    input logic                       m_ready,
    input prs_pkg::prs_out_t          m_data
);
    import prs_pkg::*;

    // reset empties the result register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // an accepted arrival gets its verdict on the next cycle
    a_arrival_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.kind == KIND_ARRIVE |=>
            m_valid && !m_data.is_release && m_data.last &&
            m_data.out_handle == $past(s_data.pkt_handle) &&
            m_data.out_direction == $past(s_data.direction))
        else $error("arrival verdict missing or wrong");

    // a verdict never carries the discard flag and always closes its request
    a_verdict_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.is_release |-> !m_data.discarded && m_data.last)
        else $error("bad verdict result");

    // releases carry a zero verdict code
    a_release_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_release |-> m_data.verdict == VERDICT_PASS)
        else $error("release with nonzero verdict");

endmodule

bind packet_rate_shaper_unit prs_checker u_prs_checker (.*);
